[sv/cma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg - shared types and constants of the centered moving average
// Holds the configuration word width and the divider status bundle.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Width of the radius configuration word
  localparam int CFG_W = 5;

  // Status of the iterative divider as seen by the controller
  typedef struct packed {
    logic busy;   // iteration in progress
    logic done;   // one-cycle pulse, quotient valid
  } div_stat_t;

endpackage

[sv/cma_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_if - channel interfaces of the centered moving average
// Sample input, result output and radius configuration channels.
// ----------------------------------------------------------------------------

// Input sample channel
interface cma_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface

// Result channel
interface cma_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic signed [SAMPLE_BITS:0] average;
  logic                      is_final;

  modport source (output valid, output average, output is_final, input ready);
  modport sink   (input valid, input average, input is_final, output ready);
endinterface

// Radius configuration channel
interface cma_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cma_pkg::CFG_W-1:0]  radius;

  modport source (output valid, output radius, input ready);
  modport sink   (input valid, input radius, output ready);
endinterface

[sv/cma_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_cell - one stage of the sample delay chain
// Loads the new sample when it is the window tail, else its upper neighbor.
// ----------------------------------------------------------------------------
module cma_cell #(
  parameter int IDX   = 0,
  parameter int W     = 16,
  parameter int IDX_W = 7
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [IDX_W-1:0] tail_idx,
  input  logic [W-1:0]     sample,
  input  logic [W-1:0]     nbr_data,
  output logic [W-1:0]     data
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;
  logic         is_tail;

  // this cell is where new samples enter the window
  assign is_tail = (tail_idx == IDX_W'(IDX));

  always_comb begin
    data_nxt = data_r;
    if (shift) begin
      data_nxt = is_tail ? sample : nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[sv/cma_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_divider - restoring divider, one quotient bit per cycle
// Divides the window sum by the window size.
// ----------------------------------------------------------------------------
module cma_divider #(
  parameter int DVD_W = 22,
  parameter int DIV_W = 7,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output cma_pkg::div_stat_t stat,
  output logic [Q_W-1:0]   quotient
);
  import cma_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             ge;

  // one restoring step
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r[Q_W-1:0];

endmodule

[sv/centered_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average - centered moving average over a sample stream
// Delay chain of cells, running window sum, serial divider, result sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                          | transaction
//  in_ch    | in  | sample, is_last                  | valid & ready
//  out_ch   | out | average (signed), is_final       | valid & ready
//  cfg_ch   | in  | radius (saturated to MAX_RADIUS) | valid & ready
//
//  A sample whose window is full passes through the bit-serial divider
//  before its result is ready; other samples skip the divider. Each result
//  passes through the output register, and a last sample adds up to
//  radius trailing results.
//  No clearing pass after reset; a radius write restarts the stream.
//  A stalled output only holds the sequencer; input is taken in idle only.
// ----------------------------------------------------------------------------
module centered_moving_average #(
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  cma_in_if.sink    in_ch,
  cma_out_if.source out_ch,
  cma_cfg_if.sink   cfg_ch
);
  import cma_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W      = RAD_W + 1;
  localparam int SUM_W      = SAMPLE_BITS + $clog2(HIST_DEPTH);
  localparam int AVG_W      = SAMPLE_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [RAD_W-1:0]       radius_r, radius_nxt;
  logic [WIN_W-1:0]       seen_r, seen_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic                   last_r, last_nxt;
  logic                   pend_r, pend_nxt;
  logic [RAD_W-1:0]       trail_r, trail_nxt;
  logic [AVG_W-1:0]       avg_r, avg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]       out_avg_r, out_avg_nxt;
  logic                   out_fin_r, out_fin_nxt;

  logic                   in_acc;
  logic                   slot_free;
  logic [WIN_W-1:0]       win;
  logic [WIN_W-1:0]       tail_idx;
  logic [WIN_W-1:0]       count;
  logic                   regular;
  logic                   full;
  logic [RAD_W-1:0]       remaining;
  logic [SAMPLE_BITS-1:0] drop;
  logic [SUM_W-1:0]       sum_acc;
  logic [31:0]            cfg_ext;
  logic [RAD_W-1:0]       cfg_sat;
  logic                   div_start;
  div_stat_t              div_stat;
  logic [SAMPLE_BITS-1:0] quotient;
  logic [SAMPLE_BITS-1:0] cell_q [HIST_DEPTH];

  // handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_ch.ready;

  // window geometry
  assign win      = {radius_r, 1'b1};
  assign tail_idx = {radius_r, 1'b0};

  // delay chain: cell 0 holds the oldest sample of the window
  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] nbr;
    if (i == HIST_DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    cma_cell #(
      .IDX   (i),
      .W     (SAMPLE_BITS),
      .IDX_W (WIN_W)
    ) u_cell (
      .clk      (clk),
      .shift    (in_acc),
      .tail_idx (tail_idx),
      .sample   (in_ch.sample),
      .nbr_data (nbr),
      .data     (cell_q[i])
    );
  end

  // running sum and position bookkeeping
  assign drop      = (seen_r >= win) ? cell_q[0] : '0;
  assign sum_acc   = sum_r - SUM_W'(drop) + SUM_W'(in_ch.sample);
  assign count     = (seen_r < win) ? seen_r + 1'b1 : seen_r;
  assign regular   = (count >= ({1'b0, radius_r} + 1'b1));
  assign full      = (count >= win);
  assign remaining = regular ? radius_r : count[RAD_W-1:0];
  assign div_start = in_acc && regular && full;

  // radius saturation
  assign cfg_ext = 32'(cfg_ch.radius);
  assign cfg_sat = (cfg_ext > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_ext[RAD_W-1:0];

  cma_divider #(
    .DVD_W (SUM_W),
    .DIV_W (WIN_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (win),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // controller and result sequencer
  always_comb begin
    state_nxt     = state_r;
    radius_nxt    = radius_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    trail_nxt     = trail_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_fin_nxt   = out_fin_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sum_nxt   = in_ch.is_last ? '0 : sum_acc;
          seen_nxt  = in_ch.is_last ? '0 : count;
          last_nxt  = in_ch.is_last;
          pend_nxt  = regular;
          trail_nxt = in_ch.is_last ? remaining : '0;
          avg_nxt   = '1;
          if (regular && full) begin
            state_nxt = S_DIV;
          end else if (regular || (in_ch.is_last && remaining != '0)) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          avg_nxt   = {1'b0, quotient};
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pend_r) begin
            out_avg_nxt = avg_r;
            out_fin_nxt = last_r && (trail_r == '0);
            pend_nxt    = 1'b0;
            if (trail_r == '0) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_avg_nxt = '1;
            out_fin_nxt = (trail_r == RAD_W'(1));
            trail_nxt   = trail_r - 1'b1;
            if (trail_r == RAD_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // radius write restarts the stream
    if (cfg_ch.valid) begin
      radius_nxt = cfg_sat;
      seen_nxt   = '0;
      sum_nxt    = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RAD_W'(1);
      seen_r      <= '0;
      sum_r       <= '0;
      last_r      <= 1'b0;
      pend_r      <= 1'b0;
      trail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      seen_r      <= seen_nxt;
      sum_r       <= sum_nxt;
      last_r      <= last_nxt;
      pend_r      <= pend_nxt;
      trail_r     <= trail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    avg_r     <= avg_nxt;
    out_avg_r <= out_avg_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.average  = out_avg_r;
  assign out_ch.is_final = out_fin_r;

  // fill count never passes the window size
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= win)
    else $error("samples seen beyond window size");

  // divider runs only while the controller waits on it
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("quotient ready outside divide state");

  // end of stream clears the stream state
  a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.is_last) |=> (sum_r == '0) && (seen_r == '0))
    else $error("stream state not cleared after last sample");

endmodule
